// ----- rtl/rtkn_pkg.sv -----
`default_nettype none

package rtkn_pkg;

  localparam int DIST_W = 32;
  localparam int IDX_W = 20;
  localparam int RANK_W = 5;
  localparam int KEEP_W = 6;
  localparam logic [KEEP_W-1:0] KEEP_RESET = 6'd32;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              last_of_row;
  } request_t;

  typedef struct packed {
    logic              which_list;
    logic [RANK_W-1:0] rank;
    logic [IDX_W-1:0]  element_index;
    logic              last;
  } result_t;

  typedef struct packed {
    logic              valid;
    logic [DIST_W-1:0] key;
    logic [IDX_W-1:0]  index;
  } entry_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_SHIFT_S,
    CELL_SHIFT_L,
    CELL_CLEAR
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    logic [DIST_W-1:0] key;
    logic [IDX_W-1:0]  index;
  } cell_ctrl_t;

  typedef struct packed {
    entry_t small_e;
    entry_t large_e;
    logic   keep_small;
    logic   keep_large;
  } cell_out_t;

endpackage

`default_nettype wire

// ----- rtl/rtkn_cell.sv -----
`default_nettype none

module rtkn_cell (
  input  wire                 clk,
  input  wire                 rst,
  input  rtkn_pkg::cell_ctrl_t ctrl,
  input  rtkn_pkg::cell_out_t  left,
  input  rtkn_pkg::cell_out_t  right,
  output rtkn_pkg::cell_out_t  self
);
  import rtkn_pkg::*;

  entry_t small_e;
  entry_t large_e;
  entry_t new_e;

  always_comb begin
    new_e.valid = 1'b1;
    new_e.key = ctrl.key;
    new_e.index = ctrl.index;
    self.small_e = small_e;
    self.large_e = large_e;
    self.keep_small = small_e.valid && (small_e.key <= ctrl.key);
    self.keep_large = large_e.valid && (large_e.key > ctrl.key);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      small_e.valid <= 1'b0;
      large_e.valid <= 1'b0;
    end else begin
      unique case (ctrl.op)
        CELL_HOLD: begin
        end
        CELL_INSERT: begin
          if (!self.keep_small) begin
            small_e <= left.keep_small ? new_e : left.small_e;
          end
          if (!self.keep_large) begin
            large_e <= left.keep_large ? new_e : left.large_e;
          end
        end
        CELL_SHIFT_S: small_e <= right.small_e;
        CELL_SHIFT_L: large_e <= right.large_e;
        CELL_CLEAR: begin
          small_e.valid <= 1'b0;
          large_e.valid <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/row_top_k_nearest_farthest.sv -----
// Channel   Handshake            Payload
// request   start / busy         request (distance, last_of_row)
// config    cfg_we               cfg_data (keep_count)
// result    result_valid strobe  result (which_list, rank, element_index, last)
//
// A request that is not last is taken while idle; the next can follow at once.
// A last request inserts its element, then the block is busy while the cell
// chain shifts each list out through its first cell.
// Results lag the emitting cycle by one register; the receiver cannot stall.
// Reset is synchronous and empties both lists and the element counter.
`default_nettype none

module row_top_k_nearest_farthest #(
  parameter int KEEP_MAX = 32,
  parameter int MAX_ROW = 1048576
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          start,
  output logic                         busy,
  input  rtkn_pkg::request_t           request,
  input  wire                          cfg_we,
  input  wire [rtkn_pkg::KEEP_W-1:0]   cfg_data,
  output logic                         result_valid,
  output rtkn_pkg::result_t            result
);
  import rtkn_pkg::*;

  localparam int CNT_W = $clog2(MAX_ROW + 1);
  localparam int FILL_W = $clog2(KEEP_MAX + 1);

  typedef enum logic [1:0] {S_IDLE, S_EMIT_S, S_EMIT_L} state_t;

  state_t              state;
  logic [KEEP_W-1:0]   keep_count;
  logic [CNT_W-1:0]    counter;
  logic [FILL_W-1:0]   filled;
  logic [FILL_W-1:0]   emit_n;
  logic [FILL_W-1:0]   emit_cnt;

  logic                accept;
  logic                do_insert;
  logic [FILL_W-1:0]   filled_next;
  logic [KEEP_W-1:0]   k_eff;
  logic [FILL_W-1:0]   n_next;
  logic                emit_end;
  cell_ctrl_t          ctrl;
  cell_out_t           chain [KEEP_MAX];
  cell_out_t           edge_left;
  cell_out_t           edge_right;

  assign busy = (state != S_IDLE);
  assign accept = start && !busy;
  assign do_insert = accept && (counter < CNT_W'(MAX_ROW));
  assign emit_end = (emit_cnt + FILL_W'(1)) == emit_n;

  always_comb begin
    filled_next = filled;
    if (do_insert && (filled != FILL_W'(KEEP_MAX))) begin
      filled_next = filled + FILL_W'(1);
    end
    priority if (keep_count == '0) begin
      k_eff = KEEP_W'(1);
    end else if (keep_count > KEEP_W'(KEEP_MAX)) begin
      k_eff = KEEP_W'(KEEP_MAX);
    end else begin
      k_eff = keep_count;
    end
    if (KEEP_W'(filled_next) < k_eff) begin
      n_next = filled_next;
    end else begin
      n_next = FILL_W'(k_eff);
    end
  end

  always_comb begin
    ctrl.key = request.distance;
    ctrl.index = IDX_W'(counter);
    unique case (state)
      S_IDLE: ctrl.op = do_insert ? CELL_INSERT : CELL_HOLD;
      S_EMIT_S: ctrl.op = CELL_SHIFT_S;
      S_EMIT_L: ctrl.op = emit_end ? CELL_CLEAR : CELL_SHIFT_L;
      default: ctrl.op = CELL_HOLD;
    endcase
  end

  always_comb begin
    edge_left = '0;
    edge_left.keep_small = 1'b1;
    edge_left.keep_large = 1'b1;
    edge_right = '0;
  end

  for (genvar i = 0; i < KEEP_MAX; i++) begin : g_cell
    if (i == 0 && KEEP_MAX == 1) begin : g_only
      rtkn_cell u_cell (.clk, .rst, .ctrl, .left(edge_left), .right(edge_right),
                        .self(chain[i]));
    end else if (i == 0) begin : g_first
      rtkn_cell u_cell (.clk, .rst, .ctrl, .left(edge_left), .right(chain[i+1]),
                        .self(chain[i]));
    end else if (i == KEEP_MAX - 1) begin : g_last
      rtkn_cell u_cell (.clk, .rst, .ctrl, .left(chain[i-1]), .right(edge_right),
                        .self(chain[i]));
    end else begin : g_mid
      rtkn_cell u_cell (.clk, .rst, .ctrl, .left(chain[i-1]), .right(chain[i+1]),
                        .self(chain[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      keep_count <= KEEP_RESET;
      counter <= '0;
      filled <= '0;
      emit_n <= '0;
      emit_cnt <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        keep_count <= cfg_data;
      end
      result_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (do_insert) begin
            counter <= counter + CNT_W'(1);
            filled <= filled_next;
          end
          if (accept && request.last_of_row) begin
            emit_n <= n_next;
            emit_cnt <= '0;
            state <= S_EMIT_S;
          end
        end
        S_EMIT_S: begin
          result_valid <= 1'b1;
          result.which_list <= 1'b0;
          result.rank <= RANK_W'(emit_cnt);
          result.element_index <= chain[0].small_e.index;
          result.last <= 1'b0;
          if (emit_end) begin
            emit_cnt <= '0;
            state <= S_EMIT_L;
          end else begin
            emit_cnt <= emit_cnt + FILL_W'(1);
          end
        end
        S_EMIT_L: begin
          result_valid <= 1'b1;
          result.which_list <= 1'b1;
          result.rank <= RANK_W'(emit_cnt);
          result.element_index <= chain[0].large_e.index;
          result.last <= emit_end;
          if (emit_end) begin
            counter <= '0;
            filled <= '0;
            state <= S_IDLE;
          end else begin
            emit_cnt <= emit_cnt + FILL_W'(1);
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    busy |-> (emit_n != '0))
    else $error("output run started with an empty count");

  a_result_from_run: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy))
    else $error("result strobe outside an output run");

  a_gap_after_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.last) |=> !result_valid)
    else $error("result directly after the final result of a row");

  a_head_valid: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT_S) |-> chain[0].small_e.valid)
    else $error("emitting an empty nearest entry");

endmodule

`default_nettype wire
